// ===== src/sdrc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sprite dirty-rectangle cull package
// Shared sizes, operation and result codes, payload and storage types.
// ----------------------------------------------------------------------------
package sdrc_pkg;

   localparam int SLOT_COUNT = 8;
   localparam int RECT_COUNT = 4;

   localparam int SLOT_AW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
   localparam int RECT_AW = (RECT_COUNT > 1) ? $clog2(RECT_COUNT) : 1;

   localparam logic [2:0]         SLOT_LAST = 3'(SLOT_COUNT - 1);
   localparam logic [RECT_AW-1:0] RECT_LAST = RECT_AW'(RECT_COUNT - 1);

   localparam int FLAG_ACTIVE = 0;
   localparam int FLAG_DIRTY  = 1;
   localparam int FLAG_FLIPX  = 5;
   localparam int FLAG_FLIPY  = 6;

   typedef enum logic [1:0] {
      OP_RECT_WR = 2'd0,
      OP_SLOT_WR = 2'd1,
      OP_RENDER  = 2'd2,
      OP_FLAG_RD = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      KIND_DRAW  = 2'd0,
      KIND_ACK   = 2'd1,
      KIND_FLAGS = 2'd2
   } kind_type;

   typedef struct packed {
      logic [1:0]         operation;
      logic [2:0]         index;
      logic [2:0]         first_index;
      logic [15:0]        flags;
      logic signed [15:0] coord_a;
      logic signed [15:0] coord_b;
      logic signed [15:0] coord_c;
      logic signed [15:0] coord_d;
   } req_type;

   typedef struct packed {
      logic [1:0]         kind;
      logic [2:0]         slot_number;
      logic [1:0]         rect_number;
      logic [2:0]         blitter_select;
      logic               flip_x;
      logic               flip_y;
      logic signed [15:0] clip_left;
      logic signed [15:0] clip_right;
      logic signed [15:0] clip_top;
      logic signed [15:0] clip_bottom;
      logic [15:0]        slot_flags;
      logic               last;
   } rsp_type;

   typedef struct packed {
      logic [15:0]        flags;
      logic signed [15:0] x;
      logic signed [15:0] y;
      logic signed [15:0] width;
      logic signed [15:0] height;
   } slot_entry_type;

   typedef struct packed {
      logic signed [15:0] bottom;
      logic signed [15:0] top;
      logic signed [15:0] right;
      logic signed [15:0] left;
   } rect_type;

   localparam rect_type RECT_RESET = '{bottom: 16'sd0, top: 16'sd0, right: 16'sd0,
                                       left: -16'sd1};

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ACK,
      ST_FLAGS,
      ST_START,
      ST_SLOT,
      ST_RECT,
      ST_WBACK,
      ST_DONE
   } state_type;

endpackage

// ===== src/sdrc_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module sdrc_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 8,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== src/sprite_dirty_rect_cull_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sprite dirty-rectangle cull core
// Slot table and dirty-rectangle list in RAM; renders walk slots from last
// to first, test each active slot against the list, emit draw requests.
// ----------------------------------------------------------------------------
// Channel  Direction  Handshake              Payload
// req      in         req_valid / req_stall  sdrc_pkg::req_type
// rsp      out        rsp_valid / rsp_stall  sdrc_pkg::rsp_type
//
// A render reads, per visited slot, the slot entry and then, for active
// slots, each rectangle in turn; the rectangle RAM read port sets the
// per-test pace.
// Reset marks all RAM entries unwritten: slots read as zero, rectangles as
// the empty list. A stalled result holds the sequencer only when it has a new result to emit.
// ----------------------------------------------------------------------------
module sprite_dirty_rect_cull_core (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  sdrc_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output sdrc_pkg::rsp_type rsp_data
);
   import sdrc_pkg::*;

   state_type state_ff, state_in;

   logic [2:0]         cursor_ff, cursor_in;
   logic [2:0]         first_ff, first_in;
   logic [2:0]         idx_ff, idx_in;
   logic [RECT_AW-1:0] rect_idx_ff, rect_idx_in;
   slot_entry_type     slot_ff, slot_in;
   logic signed [15:0] right_sum_ff, right_sum_in;
   logic signed [15:0] bottom_sum_ff, bottom_sum_in;

   logic [SLOT_COUNT-1:0] slot_valid_ff;
   logic [RECT_COUNT-1:0] rect_valid_ff;
   logic                  slot_rd_vld_ff, slot_rd_vld_in;
   logic                  rect_rd_vld_ff, rect_rd_vld_in;

   logic    rsp_valid_ff;
   rsp_type rsp_data_ff;
   rsp_type rsp_next;
   logic    rsp_load;

   logic               slot_wr_en, slot_rd_en;
   logic [SLOT_AW-1:0] slot_wr_addr, slot_rd_addr;
   slot_entry_type     slot_wr_data;
   logic [79:0]        slot_ram_q;
   logic               rect_wr_en, rect_rd_en;
   logic [RECT_AW-1:0] rect_wr_addr, rect_rd_addr;
   rect_type           rect_wr_data;
   logic [63:0]        rect_ram_q;

   slot_entry_type slot_q;
   rect_type       rect_q;
   logic           accept;
   logic           out_free;
   logic           rect_empty;
   logic           overlap;
   logic [2:0]     start_last;

   sdrc_ram #(.WIDTH(80), .DEPTH(SLOT_COUNT)) u_slot_ram (
      .clock   (clock),
      .wr_en   (slot_wr_en),
      .wr_addr (slot_wr_addr),
      .wr_data (slot_wr_data),
      .rd_en   (slot_rd_en),
      .rd_addr (slot_rd_addr),
      .rd_data (slot_ram_q)
   );

   sdrc_ram #(.WIDTH(64), .DEPTH(RECT_COUNT)) u_rect_ram (
      .clock   (clock),
      .wr_en   (rect_wr_en),
      .wr_addr (rect_wr_addr),
      .wr_data (rect_wr_data),
      .rd_en   (rect_rd_en),
      .rd_addr (rect_rd_addr),
      .rd_data (rect_ram_q)
   );

   assign accept   = req_valid && !req_stall;
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign slot_q   = slot_rd_vld_ff ? slot_entry_type'(slot_ram_q) : '0;
   assign rect_q   = rect_rd_vld_ff ? rect_type'(rect_ram_q) : RECT_RESET;

   assign rect_empty = rect_q.left[15];
   assign overlap    = (slot_ff.x < rect_q.right) && (slot_ff.y < rect_q.bottom) &&
                       (right_sum_ff > rect_q.left) && (bottom_sum_ff > rect_q.top);
   assign start_last = (int'(req_data.index) >= SLOT_COUNT) ? SLOT_LAST : req_data.index;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (op_type'(req_data.operation))
                  OP_RECT_WR: state_in = ST_ACK;
                  OP_SLOT_WR: state_in = ST_ACK;
                  OP_RENDER:  state_in = ST_START;
                  OP_FLAG_RD: state_in = ST_FLAGS;
                  default:    state_in = ST_IDLE;
               endcase
            end
         end
         ST_ACK, ST_DONE, ST_FLAGS: begin
            if (out_free) state_in = ST_IDLE;
         end
         ST_START: begin
            if (rect_empty || (first_ff > cursor_ff)) state_in = ST_DONE;
            else state_in = ST_SLOT;
         end
         ST_SLOT: begin
            if (slot_q.flags[FLAG_ACTIVE]) state_in = ST_RECT;
            else state_in = ST_WBACK;
         end
         ST_RECT: begin
            if (rect_empty) state_in = ST_WBACK;
            else if (overlap && !out_free) state_in = ST_RECT;
            else if (rect_idx_ff == RECT_LAST) state_in = ST_WBACK;
            else state_in = ST_RECT;
         end
         ST_WBACK: begin
            if (cursor_ff == first_ff) state_in = ST_DONE;
            else state_in = ST_SLOT;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_stall      = 1'b1;
      slot_wr_en     = 1'b0;
      slot_wr_addr   = cursor_ff[SLOT_AW-1:0];
      slot_wr_data   = slot_ff;
      slot_rd_en     = 1'b0;
      slot_rd_addr   = cursor_ff[SLOT_AW-1:0];
      rect_wr_en     = 1'b0;
      rect_wr_addr   = req_data.index[RECT_AW-1:0];
      rect_wr_data   = '{bottom: req_data.coord_d, top: req_data.coord_c,
                         right: req_data.coord_b, left: req_data.coord_a};
      rect_rd_en     = 1'b0;
      rect_rd_addr   = '0;
      rsp_load       = 1'b0;
      rsp_next       = '0;
      cursor_in      = cursor_ff;
      first_in       = first_ff;
      idx_in         = idx_ff;
      rect_idx_in    = rect_idx_ff;
      slot_in        = slot_ff;
      right_sum_in   = right_sum_ff;
      bottom_sum_in  = bottom_sum_ff;
      case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            if (accept) begin
               case (op_type'(req_data.operation))
                  OP_RECT_WR: begin
                     rect_wr_en = int'(req_data.index) < RECT_COUNT;
                  end
                  OP_SLOT_WR: begin
                     slot_wr_en   = int'(req_data.index) < SLOT_COUNT;
                     slot_wr_addr = req_data.index[SLOT_AW-1:0];
                     slot_wr_data = '{flags: req_data.flags, x: req_data.coord_a,
                                      y: req_data.coord_b, width: req_data.coord_c,
                                      height: req_data.coord_d};
                  end
                  OP_RENDER: begin
                     rect_rd_en = 1'b1;
                     cursor_in  = start_last;
                     first_in   = req_data.first_index;
                  end
                  OP_FLAG_RD: begin
                     slot_rd_en   = 1'b1;
                     slot_rd_addr = req_data.index[SLOT_AW-1:0];
                     idx_in       = req_data.index;
                  end
                  default: begin
                     rect_rd_en = 1'b0;
                  end
               endcase
            end
         end
         ST_ACK, ST_DONE: begin
            if (out_free) begin
               rsp_load      = 1'b1;
               rsp_next.kind = KIND_ACK;
               rsp_next.last = 1'b1;
            end
         end
         ST_FLAGS: begin
            if (out_free) begin
               rsp_load             = 1'b1;
               rsp_next.kind        = KIND_FLAGS;
               rsp_next.slot_number = idx_ff;
               rsp_next.slot_flags  = slot_q.flags;
               rsp_next.last        = 1'b1;
            end
         end
         ST_START: begin
            slot_rd_en = !(rect_empty || (first_ff > cursor_ff));
         end
         ST_SLOT: begin
            slot_in       = slot_q;
            right_sum_in  = slot_q.x + slot_q.width;
            bottom_sum_in = slot_q.y + slot_q.height;
            rect_idx_in   = '0;
            rect_rd_en    = slot_q.flags[FLAG_ACTIVE];
         end
         ST_RECT: begin
            if (!rect_empty) begin
               if (overlap && out_free) begin
                  rsp_load                = 1'b1;
                  rsp_next.kind           = KIND_DRAW;
                  rsp_next.slot_number    = cursor_ff;
                  rsp_next.rect_number    = 2'(rect_idx_ff);
                  rsp_next.blitter_select = slot_ff.flags[4:2];
                  rsp_next.flip_x         = slot_ff.flags[FLAG_FLIPX];
                  rsp_next.flip_y         = slot_ff.flags[FLAG_FLIPY];
                  rsp_next.clip_left      = rect_q.left;
                  rsp_next.clip_right     = rect_q.right;
                  rsp_next.clip_top       = rect_q.top;
                  rsp_next.clip_bottom    = rect_q.bottom;
               end
               if ((!overlap || out_free) && (rect_idx_ff != RECT_LAST)) begin
                  rect_idx_in  = rect_idx_ff + 1'b1;
                  rect_rd_en   = 1'b1;
                  rect_rd_addr = rect_idx_ff + 1'b1;
               end
            end
         end
         ST_WBACK: begin
            slot_wr_en                    = 1'b1;
            slot_wr_data.flags[FLAG_DIRTY] = 1'b0;
            if (cursor_ff != first_ff) begin
               cursor_in    = cursor_ff - 1'b1;
               slot_rd_en   = 1'b1;
               slot_rd_addr = cursor_in[SLOT_AW-1:0];
            end
         end
         default: begin
            req_stall = 1'b1;
         end
      endcase
   end

   assign slot_rd_vld_in = slot_rd_en ?
                           (slot_valid_ff[slot_rd_addr] &&
                            (state_ff != ST_IDLE || int'(req_data.index) < SLOT_COUNT)) :
                           slot_rd_vld_ff;
   assign rect_rd_vld_in = rect_rd_en ? rect_valid_ff[rect_rd_addr] : rect_rd_vld_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         slot_valid_ff  <= '0;
         rect_valid_ff  <= '0;
         slot_rd_vld_ff <= 1'b0;
         rect_rd_vld_ff <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         slot_rd_vld_ff <= slot_rd_vld_in;
         rect_rd_vld_ff <= rect_rd_vld_in;
         if (slot_wr_en) slot_valid_ff[slot_wr_addr] <= 1'b1;
         if (rect_wr_en) rect_valid_ff[rect_wr_addr] <= 1'b1;
         if (rsp_load) rsp_valid_ff <= 1'b1;
         else if (!rsp_stall) rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      cursor_ff     <= cursor_in;
      first_ff      <= first_in;
      idx_ff        <= idx_in;
      rect_idx_ff   <= rect_idx_in;
      slot_ff       <= slot_in;
      right_sum_ff  <= right_sum_in;
      bottom_sum_ff <= bottom_sum_in;
      if (rsp_load) rsp_data_ff <= rsp_next;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ===== src/sdrc_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sprite dirty-rectangle cull port checker
// Port-level properties of the cull core, attached by bind.
// ----------------------------------------------------------------------------
module sdrc_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_stall,
   input sdrc_pkg::req_type req_data,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input sdrc_pkg::rsp_type rsp_data
);
   import sdrc_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result changed");

   a_busy_after_req: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("request accepted on back-to-back cycles");

   a_last_kind: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_data.kind == KIND_DRAW) != rsp_data.last))
      else $error("last flag does not match result kind");

   a_clip_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.kind != KIND_DRAW |->
         rsp_data.clip_left == 16'sd0 && rsp_data.clip_right == 16'sd0 &&
         rsp_data.blitter_select == 3'd0)
      else $error("non-draw result carries draw fields");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind sprite_dirty_rect_cull_core sdrc_checker u_sdrc_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);

// ===== test/sprite_dirty_rect_cull_core_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sprite dirty-rectangle cull core testbench
// Drives rectangle writes, slot writes, flag reads and render requests
// through the request channel with random idle bursts on both sides. Each
// accepted request runs through a behavioral copy of the slot table and
// rectangle list, and every result is checked field by field in order.
// ----------------------------------------------------------------------------
module sprite_dirty_rect_cull_core_tb;
   import sdrc_pkg::*;

   localparam int RANDOM_REQUESTS = 300;
   localparam int QUIET_TAIL      = 60;
   localparam int LONG_HOLD       = 300;
   localparam int HOLD_AT         = 60;
   localparam int DRAIN_CYCLES    = 60;
   localparam int CYCLE_LIMIT     = 400000;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   req_type        request_q[$];
   rsp_type        cull_result_q[$];
   slot_entry_type slot_table[SLOT_COUNT];
   rect_type       rect_list[RECT_COUNT];

   int  requests_accepted = 0;
   int  quiet_from        = 1 << 30;
   int  send_gap          = 0;
   int  stall_left        = 0;
   int  mismatch_count    = 0;
   int  cycle_count       = 0;
   logic long_hold_done   = 1'b0;
   logic quiet;
   rsp_type expected_rsp;

   assign quiet = (requests_accepted >= quiet_from);

   sprite_dirty_rect_cull_core u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always #4 clock = ~clock;

   function automatic void cull_model_step(req_type rq);
      rsp_type            r;
      slot_entry_type     sl;
      rect_type           rc;
      logic signed [15:0] right_sum;
      logic signed [15:0] bottom_sum;
      int                 hi;
      int                 lo;
      r = '0;
      case (rq.operation)
         OP_RECT_WR: begin
            if (rq.index < RECT_COUNT)
               rect_list[rq.index[RECT_AW-1:0]] = '{bottom: rq.coord_d, top: rq.coord_c,
                                                    right: rq.coord_b, left: rq.coord_a};
            r.kind = KIND_ACK;
            r.last = 1'b1;
         end
         OP_SLOT_WR: begin
            if (rq.index < SLOT_COUNT)
               slot_table[rq.index] = '{flags: rq.flags, x: rq.coord_a, y: rq.coord_b,
                                        width: rq.coord_c, height: rq.coord_d};
            r.kind = KIND_ACK;
            r.last = 1'b1;
         end
         OP_FLAG_RD: begin
            r.kind        = KIND_FLAGS;
            r.slot_number = rq.index;
            r.slot_flags  = (rq.index < SLOT_COUNT) ? slot_table[rq.index].flags : 16'h0;
            r.last        = 1'b1;
         end
         default: begin
            if (rect_list[0].left >= 0) begin
               hi = (rq.index >= SLOT_COUNT) ? SLOT_COUNT - 1 : int'(rq.index);
               lo = int'(rq.first_index);
               for (int s = hi; s >= lo; s--) begin
                  sl = slot_table[s[SLOT_AW-1:0]];
                  if (sl.flags[FLAG_ACTIVE]) begin
                     right_sum  = sl.x + sl.width;
                     bottom_sum = sl.y + sl.height;
                     for (int k = 0; k < RECT_COUNT; k++) begin
                        rc = rect_list[k[RECT_AW-1:0]];
                        if (rc.left < 0)
                           break;
                        if (sl.x < rc.right && sl.y < rc.bottom &&
                            right_sum > rc.left && bottom_sum > rc.top) begin
                           r                = '0;
                           r.kind           = KIND_DRAW;
                           r.slot_number    = s[2:0];
                           r.rect_number    = k[1:0];
                           r.blitter_select = sl.flags[4:2];
                           r.flip_x         = sl.flags[FLAG_FLIPX];
                           r.flip_y         = sl.flags[FLAG_FLIPY];
                           r.clip_left      = rc.left;
                           r.clip_right     = rc.right;
                           r.clip_top       = rc.top;
                           r.clip_bottom    = rc.bottom;
                           cull_result_q.push_back(r);
                        end
                     end
                  end
                  slot_table[s[SLOT_AW-1:0]].flags[FLAG_DIRTY] = 1'b0;
               end
            end
            r      = '0;
            r.kind = KIND_ACK;
            r.last = 1'b1;
         end
      endcase
      cull_result_q.push_back(r);
   endfunction

   function automatic string describe(rsp_type r);
      return $sformatf({"kind=%0d slot=%0d rect=%0d blit=%0d fx=%b fy=%b ",
                        "clip=%0d,%0d,%0d,%0d flags=%h last=%b"},
                       r.kind, r.slot_number, r.rect_number, r.blitter_select, r.flip_x,
                       r.flip_y, r.clip_left, r.clip_right, r.clip_top, r.clip_bottom,
                       r.slot_flags, r.last);
   endfunction

   task automatic queue_request(op_type op, logic [2:0] idx, logic [2:0] first,
                                logic [15:0] fl, logic signed [15:0] a,
                                logic signed [15:0] b, logic signed [15:0] c,
                                logic signed [15:0] d);
      request_q.push_back('{operation: op, index: idx, first_index: first, flags: fl,
                            coord_a: a, coord_b: b, coord_c: c, coord_d: d});
   endtask

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         req_data  <= '0;
         send_gap  <= 0;
      end else begin
         if (req_valid && !req_stall) begin
            cull_model_step(req_data);
            requests_accepted <= requests_accepted + 1;
         end
         if (!req_valid || !req_stall) begin
            if (send_gap > 0) begin
               send_gap  <= send_gap - 1;
               req_valid <= 1'b0;
            end else if (request_q.size() > 0) begin
               if (!quiet && $urandom_range(0, 9) == 0) begin
                  send_gap  <= $urandom_range(0, 4);
                  req_valid <= 1'b0;
               end else begin
                  req_data  <= request_q.pop_front();
                  req_valid <= 1'b1;
               end
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall  <= 1'b0;
         stall_left <= 0;
      end else if (!long_hold_done && requests_accepted >= HOLD_AT) begin
         rsp_stall      <= 1'b1;
         stall_left     <= LONG_HOLD - 1;
         long_hold_done <= 1'b1;
      end else if (stall_left > 0) begin
         rsp_stall  <= 1'b1;
         stall_left <= stall_left - 1;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
         rsp_stall  <= 1'b1;
         stall_left <= $urandom_range(0, 4);
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (cull_result_q.size() == 0) begin
            if (mismatch_count < 10)
               $display("unexpected result: %s", describe(rsp_data));
            mismatch_count <= mismatch_count + 1;
         end else begin
            expected_rsp = cull_result_q.pop_front();
            if (rsp_data.kind !== expected_rsp.kind ||
                rsp_data.slot_number !== expected_rsp.slot_number ||
                rsp_data.rect_number !== expected_rsp.rect_number ||
                rsp_data.blitter_select !== expected_rsp.blitter_select ||
                rsp_data.flip_x !== expected_rsp.flip_x ||
                rsp_data.flip_y !== expected_rsp.flip_y ||
                rsp_data.clip_left !== expected_rsp.clip_left ||
                rsp_data.clip_right !== expected_rsp.clip_right ||
                rsp_data.clip_top !== expected_rsp.clip_top ||
                rsp_data.clip_bottom !== expected_rsp.clip_bottom ||
                rsp_data.slot_flags !== expected_rsp.slot_flags ||
                rsp_data.last !== expected_rsp.last) begin
               if (mismatch_count < 10)
                  $display("mismatch: expected %s\n          actual   %s",
                           describe(expected_rsp), describe(rsp_data));
               mismatch_count <= mismatch_count + 1;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   initial begin
      req_type rq;
      int      pick;
      for (int s = 0; s < SLOT_COUNT; s++)
         slot_table[s[SLOT_AW-1:0]] = '0;
      for (int k = 0; k < RECT_COUNT; k++)
         rect_list[k[RECT_AW-1:0]] = RECT_RESET;

      // empty list and untouched table after reset
      queue_request(OP_RENDER, 3'd7, 3'd0, 16'h0, 16'sd0, 16'sd0, 16'sd0, 16'sd0);
      queue_request(OP_FLAG_RD, 3'd0, 3'd0, 16'h0, 16'sd0, 16'sd0, 16'sd0, 16'sd0);
      queue_request(OP_RECT_WR, 3'd0, 3'd0, 16'h0, 16'sd0, 16'sd100, 16'sd0, 16'sd100);
      queue_request(OP_RECT_WR, 3'd1, 3'd0, 16'h0, 16'sd50, 16'sd150, 16'sd50, 16'sd150);
      queue_request(OP_RECT_WR, 3'd2, 3'd0, 16'h0, -16'sd1, 16'sd0, 16'sd0, 16'sd0);
      queue_request(OP_RECT_WR, 3'd3, 3'd7, 16'hFFFF, 16'sh7FFF, -16'sh8000, 16'sh7FFF,
                    -16'sh8000);
      queue_request(OP_RECT_WR, 3'd7, 3'd0, 16'h0, 16'sd0, 16'sd0, 16'sd0, 16'sd0);
      queue_request(OP_SLOT_WR, 3'd0, 3'd0, 16'h007F, 16'sd10, 16'sd10, 16'sd20, 16'sd20);
      queue_request(OP_SLOT_WR, 3'd7, 3'd0, 16'h0003, 16'sd60, 16'sd60, 16'sd50, 16'sd50);
      queue_request(OP_SLOT_WR, 3'd3, 3'd0, 16'h0002, 16'sd0, 16'sd0, 16'sd50, 16'sd50);
      queue_request(OP_SLOT_WR, 3'd5, 3'd0, 16'hFFFF, 16'sh7FFF, 16'sd10, 16'sd1, 16'sd10);
      queue_request(OP_SLOT_WR, 3'd6, 3'd0, 16'h0001, -16'sh8000, -16'sh8000, -16'sd1,
                    -16'sd1);
      queue_request(OP_RENDER, 3'd7, 3'd0, 16'h0, 16'sd0, 16'sd0, 16'sd0, 16'sd0);
      queue_request(OP_FLAG_RD, 3'd0, 3'd0, 16'h0, 16'sd0, 16'sd0, 16'sd0, 16'sd0);
      queue_request(OP_FLAG_RD, 3'd3, 3'd0, 16'h0, 16'sd0, 16'sd0, 16'sd0, 16'sd0);
      queue_request(OP_FLAG_RD, 3'd5, 3'd0, 16'h0, 16'sd0, 16'sd0, 16'sd0, 16'sd0);
      queue_request(OP_RENDER, 3'd2, 3'd5, 16'h0, 16'sd0, 16'sd0, 16'sd0, 16'sd0);
      queue_request(OP_RENDER, 3'd7, 3'd7, 16'h0, 16'sd0, 16'sd0, 16'sd0, 16'sd0);
      queue_request(OP_RECT_WR, 3'd2, 3'd0, 16'h0, 16'sd0, 16'sh7FFF, -16'sh8000,
                    16'sh7FFF);
      queue_request(OP_SLOT_WR, 3'd3, 3'd0, 16'h0063, 16'sd5, 16'sd5, 16'sd5, 16'sd5);
      queue_request(OP_RENDER, 3'd7, 3'd0, 16'h0, 16'sd0, 16'sd0, 16'sd0, 16'sd0);
      queue_request(OP_RECT_WR, 3'd0, 3'd0, 16'h0, -16'sh8000, 16'sd100, 16'sd0, 16'sd100);
      queue_request(OP_RENDER, 3'd7, 3'd0, 16'h0, 16'sd0, 16'sd0, 16'sd0, 16'sd0);
      queue_request(OP_RECT_WR, 3'd0, 3'd0, 16'h0, 16'sd0, 16'sd100, 16'sd0, 16'sd100);
      queue_request(OP_RENDER, 3'd7, 3'd0, 16'h0, 16'sd0, 16'sd0, 16'sd0, 16'sd0);

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // hold the sender until the directed part has fully drained
      while (request_q.size() > 0 || req_valid || cull_result_q.size() > 0)
         @(posedge clock);

      for (int n = 0; n < RANDOM_REQUESTS; n++) begin
         rq             = '0;
         rq.index       = 3'($urandom_range(0, 7));
         rq.first_index = 3'($urandom_range(0, 7));
         rq.flags       = 16'($urandom);
         pick           = $urandom_range(0, 99);
         if (pick < 20) begin
            rq.operation = OP_RECT_WR;
            rq.index     = 3'(($urandom_range(0, 9) < 8) ? $urandom_range(0, 3)
                                                         : $urandom_range(4, 7));
            if ($urandom_range(0, 9) == 0) begin
               rq.coord_a = 16'($urandom);
               rq.coord_b = 16'($urandom);
               rq.coord_c = 16'($urandom);
               rq.coord_d = 16'($urandom);
            end else begin
               rq.coord_a = 16'(($urandom_range(0, 7) == 0) ? -$urandom_range(1, 300)
                                                            : $urandom_range(0, 300));
               rq.coord_b = 16'(rq.coord_a + $urandom_range(0, 200));
               rq.coord_c = 16'($urandom_range(0, 300));
               rq.coord_d = 16'(rq.coord_c + $urandom_range(0, 200));
            end
         end else if (pick < 55) begin
            rq.operation = OP_SLOT_WR;
            rq.flags[FLAG_ACTIVE] = ($urandom_range(0, 3) != 0);
            if ($urandom_range(0, 9) == 0) begin
               rq.coord_a = 16'($urandom);
               rq.coord_b = 16'($urandom);
               rq.coord_c = 16'($urandom);
               rq.coord_d = 16'($urandom);
            end else begin
               rq.coord_a = 16'($urandom_range(0, 500) - 100);
               rq.coord_b = 16'($urandom_range(0, 500) - 100);
               rq.coord_c = 16'($urandom_range(0, 150));
               rq.coord_d = 16'($urandom_range(0, 150));
            end
         end else if (pick < 85) begin
            rq.operation   = OP_RENDER;
            rq.first_index = 3'(($urandom_range(0, 9) == 0) ? $urandom_range(0, 7)
                                                            : $urandom_range(0, rq.index));
         end else begin
            rq.operation = OP_FLAG_RD;
         end
         request_q.push_back(rq);
      end
      quiet_from = requests_accepted + request_q.size() - QUIET_TAIL;

      while (request_q.size() > 0 || req_valid || cull_result_q.size() > 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatch_count == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule
